// File: rtl/pdr_pkg.sv
package pdr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_W        = 48;
    localparam int TIME_W       = 32;
    localparam int SMP_W        = 16;
    localparam int IDX_W        = 32;
    localparam int SKIP_W       = 16;
    localparam int ANG_W        = 32;
    localparam int ROT_W        = 34;
    localparam int GAIN_W       = 64;
    localparam int RAX_W        = 32;
    localparam int LO_W         = POS_W / 2;
    localparam int HI_W         = POS_W - LO_W;
    localparam int PP_W         = HI_W + TIME_W;
    localparam int PROD_W       = POS_W + TIME_W;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [GAIN_W-1:0] KGAIN = 64'sd652032874;

    typedef enum logic
    {
        ITEM_GYRO,
        ITEM_ACCEL
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t               kind;
        logic [TIME_W-1:0]        dt;
        logic signed [SMP_W-1:0]  rate;
        logic                     emit;
        logic                     skip;
        logic [IDX_W-1:0]         idx;
        logic signed [SMP_W-1:0]  ax;
        logic signed [SMP_W-1:0]  ay;
    } pdr_item_t;

    typedef enum logic [3:0]
    {
        B_IDLE,
        B_GYRO_MUL,
        B_GYRO_ADD,
        B_MUL_LO,
        B_MUL_HI,
        B_ACC,
        B_APPLY,
        B_EMIT,
        B_ROT_INIT,
        B_ROT_STEP,
        B_GAIN_X,
        B_GAIN_Y,
        B_ROUND
    } back_state_t;

    function automatic logic [ANG_W-1:0] atan_lookup(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/pdr_in_if.sv
interface pdr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic [pdr_pkg::TIME_W-1:0]             sample_time;
    logic signed [pdr_pkg::SMP_W-1:0]       gyro_rate;
    logic signed [pdr_pkg::SMP_W-1:0]       accel_x;
    logic signed [pdr_pkg::SMP_W-1:0]       accel_y;

    modport source (output valid, op, sample_time, gyro_rate, accel_x, accel_y, input ready);
    modport sink (input valid, op, sample_time, gyro_rate, accel_x, accel_y, output ready);
endinterface

// File: rtl/pdr_out_if.sv
interface pdr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [pdr_pkg::IDX_W-1:0]              sample_index;
    logic signed [pdr_pkg::POS_W-1:0]       pos_x;
    logic signed [pdr_pkg::POS_W-1:0]       pos_y;

    modport source (output valid, sample_index, pos_x, pos_y, input ready);
    modport sink (input valid, sample_index, pos_x, pos_y, output ready);
endinterface

// File: rtl/planar_dead_reckoning.sv
// Channel   Modport   Word
// sensor    sink      op, sample_time, gyro_rate, accel_x, accel_y
// result    source    sample_index, pos_x, pos_y
// cfg       write     cfg_we, cfg_wdata (skip_count)
//
// In the back end a gyro word is popped, multiplied and added to the heading.
// An accel word is popped, runs the four split multiplies unless it is first
// or skipped, emits its fix unless it is first, then runs 16 CORDIC steps,
// setup and gain. The four multiplies share one 24 by 32 bit multiplier.
// A two-word queue lets the front accept words while the back end is busy.
// Not all state is reset; the output register holds its word until it is taken.
module planar_dead_reckoning
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pdr_pkg::SKIP_W-1:0]  cfg_wdata,
    pdr_in_if.sink                      sensor,
    pdr_out_if.source                   result
);
    import pdr_pkg::*;

    logic      q_full, q_empty, push, pop;
    pdr_item_t push_item, head;

    pdr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sensor    (sensor),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    pdr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    pdr_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (pop),
        .result (result)
    );

endmodule

// File: rtl/pdr_front.sv
module pdr_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pdr_pkg::SKIP_W-1:0]  cfg_wdata,
    pdr_in_if.sink                      sensor,
    input  logic                        q_full,
    output logic                        push,
    output pdr_pkg::pdr_item_t          push_item
);
    import pdr_pkg::*;

    logic [SKIP_W-1:0]       skip_count_reg;
    logic [TIME_W-1:0]       prev_gyro_time_reg, prev_gyro_time_next;
    logic signed [SMP_W-1:0] prev_gyro_rate_reg, prev_gyro_rate_next;
    logic                    gyro_seen_reg, gyro_seen_next;
    logic [TIME_W-1:0]       prev_accel_time_reg, prev_accel_time_next;
    logic [IDX_W-1:0]        accel_count_reg, accel_count_next;
    logic [IDX_W-1:0]        idx;

    assign sensor.ready = !q_full;
    assign push         = sensor.valid && !q_full;
    assign idx          = accel_count_reg - IDX_W'(1);

    always_comb
    begin
        push_item.kind = sensor.op ? ITEM_ACCEL : ITEM_GYRO;
        push_item.rate = prev_gyro_rate_reg;
        push_item.emit = (accel_count_reg != '0);
        push_item.skip = (idx < IDX_W'(skip_count_reg));
        push_item.idx  = idx;
        push_item.ax   = sensor.accel_x;
        push_item.ay   = sensor.accel_y;
        if (sensor.op)
        begin
            push_item.dt = sensor.sample_time - prev_accel_time_reg;
        end
        else if (gyro_seen_reg)
        begin
            push_item.dt = sensor.sample_time - prev_gyro_time_reg;
        end
        else
        begin
            push_item.dt = '0;
        end

        prev_gyro_time_next  = prev_gyro_time_reg;
        prev_gyro_rate_next  = prev_gyro_rate_reg;
        gyro_seen_next       = gyro_seen_reg;
        prev_accel_time_next = prev_accel_time_reg;
        accel_count_next     = accel_count_reg;
        if (push)
        begin
            if (sensor.op)
            begin
                prev_accel_time_next = sensor.sample_time;
                if (accel_count_reg != '1)
                begin
                    accel_count_next = accel_count_reg + IDX_W'(1);
                end
            end
            else
            begin
                prev_gyro_time_next = sensor.sample_time;
                prev_gyro_rate_next = sensor.gyro_rate;
                gyro_seen_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg      <= '0;
            prev_gyro_time_reg  <= '0;
            prev_gyro_rate_reg  <= '0;
            gyro_seen_reg       <= 1'b0;
            prev_accel_time_reg <= '0;
            accel_count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                skip_count_reg <= cfg_wdata;
            end
            prev_gyro_time_reg  <= prev_gyro_time_next;
            prev_gyro_rate_reg  <= prev_gyro_rate_next;
            gyro_seen_reg       <= gyro_seen_next;
            prev_accel_time_reg <= prev_accel_time_next;
            accel_count_reg     <= accel_count_next;
        end
    end

endmodule

// File: rtl/pdr_queue.sv
module pdr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pdr_pkg::pdr_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output pdr_pkg::pdr_item_t  head,
    output logic                empty
);
    import pdr_pkg::*;

    pdr_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/pdr_back.sv
module pdr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  pdr_pkg::pdr_item_t  head,
    input  logic                empty,
    output logic                pop,
    pdr_out_if.source           result
);
    import pdr_pkg::*;

    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [ROT_W-1:0] QTURN = ROT_W'(64'sd1073741824);
    localparam logic signed [ROT_W-1:0] HTURN = ROT_W'(64'sd2147483648);
    localparam logic signed [GAIN_W-1:0] ROUND_HALF = 64'sd8796093022208;

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                        input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] s;
        s = (POS_W+1)'(a) + (POS_W+1)'(b);
        if (s > (POS_W+1)'(PMAX))
        begin
            return PMAX;
        end
        else if (s < (POS_W+1)'(PMIN))
        begin
            return PMIN;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [RAX_W-1:0] round_gain(input logic signed [GAIN_W-1:0] p);
        logic signed [GAIN_W-1:0] t;
        t = (p + ROUND_HALF) >>> 44;
        return t[RAX_W-1:0];
    endfunction

    back_state_t              state_reg, state_next;
    pdr_item_t                cur_reg, cur_next;
    logic [1:0]               sel_reg, sel_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [ANG_W-1:0]         heading_reg, heading_next;
    logic signed [RAX_W-1:0]  rax_reg, rax_next, ray_reg, ray_next;
    logic signed [POS_W-1:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic [PP_W-1:0]          pp_reg, pp_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic signed [ROT_W-1:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [GAIN_W-1:0] gain_reg, gain_next;
    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic signed [POS_W-1:0]  out_px_reg, out_px_next, out_py_reg, out_py_next;

    logic signed [POS_W-1:0]  operand, term, target;
    logic                     op_neg, sat;
    logic [POS_W-1:0]         mag;
    logic [PROD_W-1:0]        lim;
    logic [ANG_W-1:0]         gyro_prod, zu;
    logic signed [ROT_W-1:0]  z0, x0, y0, dx, dy;

    assign result.valid        = out_valid_reg;
    assign result.sample_index = out_idx_reg;
    assign result.pos_x        = out_px_reg;
    assign result.pos_y        = out_py_reg;

    always_comb
    begin
        case (sel_reg)
            2'd0:    operand = POS_W'(rax_reg);
            2'd1:    operand = POS_W'(ray_reg);
            2'd2:    operand = vx_reg;
            default: operand = vy_reg;
        endcase
        case (sel_reg)
            2'd0:    target = vx_reg;
            2'd1:    target = vy_reg;
            2'd2:    target = px_reg;
            default: target = py_reg;
        endcase
        op_neg = operand[POS_W-1];
        mag    = op_neg ? POS_W'(-operand) : POS_W'(operand);
        lim    = op_neg ? PROD_W'(PMAX) + PROD_W'(1) : PROD_W'(PMAX);
        sat    = (prod_reg > lim);
        if (sat)
        begin
            term = op_neg ? PMIN : PMAX;
        end
        else
        begin
            term = op_neg ? -prod_reg[POS_W-1:0] : prod_reg[POS_W-1:0];
        end

        gyro_prod = ANG_W'(32'(cur_reg.rate)) * cur_reg.dt;

        zu = -heading_reg;
        z0 = ROT_W'($signed(zu));
        x0 = ROT_W'(cur_reg.ax) <<< 14;
        y0 = ROT_W'(cur_reg.ay) <<< 14;
        if (z0 > QTURN || z0 < -QTURN)
        begin
            z0 = (z0 > 0) ? z0 - HTURN : z0 + HTURN;
            x0 = -x0;
            y0 = -y0;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;

        state_next     = state_reg;
        cur_next       = cur_reg;
        sel_next       = sel_reg;
        step_next      = step_reg;
        heading_next   = heading_reg;
        rax_next       = rax_reg;
        ray_next       = ray_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_idx_next   = out_idx_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        pop            = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    sel_next = 2'd0;
                    if (head.kind == ITEM_GYRO)
                    begin
                        state_next = B_GYRO_MUL;
                    end
                    else if (!head.emit)
                    begin
                        state_next = B_ROT_INIT;
                    end
                    else if (head.skip)
                    begin
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_MUL_LO;
                    end
                end
            end
            B_GYRO_MUL:
            begin
                pp_next    = PP_W'(gyro_prod);
                state_next = B_GYRO_ADD;
            end
            B_GYRO_ADD:
            begin
                heading_next = heading_reg + pp_reg[ANG_W-1:0];
                state_next   = B_IDLE;
            end
            B_MUL_LO:
            begin
                pp_next    = PP_W'(mag[LO_W-1:0]) * PP_W'(cur_reg.dt);
                state_next = B_MUL_HI;
            end
            B_MUL_HI:
            begin
                pp_next    = PP_W'(mag[POS_W-1:LO_W]) * PP_W'(cur_reg.dt);
                prod_next  = PROD_W'(pp_reg);
                state_next = B_ACC;
            end
            B_ACC:
            begin
                prod_next  = prod_reg + (PROD_W'(pp_reg) << LO_W);
                state_next = B_APPLY;
            end
            B_APPLY:
            begin
                case (sel_reg)
                    2'd0:    vx_next = sat_add(target, term);
                    2'd1:    vy_next = sat_add(target, term);
                    2'd2:    px_next = sat_add(target, term);
                    default: py_next = sat_add(target, term);
                endcase
                sel_next   = sel_reg + 2'd1;
                state_next = (sel_reg == 2'd3) ? B_EMIT : B_MUL_LO;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = cur_reg.idx;
                    out_px_next    = cur_reg.skip ? '0 : px_reg;
                    out_py_next    = cur_reg.skip ? '0 : py_reg;
                    state_next     = B_ROT_INIT;
                end
            end
            B_ROT_INIT:
            begin
                x_next     = x0;
                y_next     = y0;
                z_next     = z0;
                step_next  = '0;
                state_next = B_ROT_STEP;
            end
            B_ROT_STEP:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - ROT_W'(atan_lookup(5'(step_reg)));
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + ROT_W'(atan_lookup(5'(step_reg)));
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = B_GAIN_X;
                end
            end
            B_GAIN_X:
            begin
                gain_next  = GAIN_W'(x_reg) * KGAIN;
                state_next = B_GAIN_Y;
            end
            B_GAIN_Y:
            begin
                rax_next   = round_gain(gain_reg);
                gain_next  = GAIN_W'(y_reg) * KGAIN;
                state_next = B_ROUND;
            end
            B_ROUND:
            begin
                ray_next   = round_gain(gain_reg);
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sel_reg       <= '0;
            step_reg      <= '0;
            heading_reg   <= '0;
            rax_reg       <= '0;
            ray_reg       <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            heading_reg   <= heading_next;
            rax_reg       <= rax_next;
            ray_reg       <= ray_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pp_reg      <= pp_next;
        prod_reg    <= prod_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        gain_reg    <= gain_next;
        out_idx_reg <= out_idx_next;
        out_px_reg  <= out_px_next;
        out_py_reg  <= out_py_next;
    end

endmodule

// File: bench/planar_dead_reckoning_test.sv
`timescale 1ns / 1ps

module planar_dead_reckoning_test;
    import pdr_pkg::*;

    localparam logic signed [95:0] POS_MAX = 96'sd140737488355327;
    localparam logic signed [95:0] POS_MIN = -96'sd140737488355328;
    localparam int QUIET_LEN = 300;

    typedef struct
    {
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
    } fix_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SKIP_W-1:0] cfg_wdata;

    pdr_in_if sensor();
    pdr_out_if result();

    planar_dead_reckoning dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .sensor(sensor),
        .result(result)
    );

    logic [31:0] arctan_tab [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // Tracker state, mirroring what the block must hold.
    logic [15:0] skip_len;
    logic [31:0] yaw;
    logic [31:0] last_gyro_t;
    logic signed [15:0] last_rate;
    logic gyro_valid;
    logic [31:0] last_accel_t;
    longint world_ax;
    longint world_ay;
    logic signed [POS_W-1:0] vx, vy, px, py;
    logic [31:0] accel_seen;

    fix_t fix_q[$];
    logic [31:0] now_t;
    bit quiet;
    int mismatches;
    int fixes_checked;
    int words_sent;
    bit failed;

    always #5 clk = ~clk;

    function automatic logic signed [POS_W-1:0] scale_sat(logic signed [POS_W-1:0] v,
                                                          logic [31:0] dt);
        logic signed [95:0] p;
        p = $signed(v) * $signed({1'b0, dt});
        if (p > POS_MAX)
            return POS_MAX[POS_W-1:0];
        if (p < POS_MIN)
            return POS_MIN[POS_W-1:0];
        return p[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] add_sat(logic signed [POS_W-1:0] a,
                                                        logic signed [POS_W-1:0] b);
        logic signed [95:0] s;
        s = $signed(a) + $signed(b);
        if (s > POS_MAX)
            return POS_MAX[POS_W-1:0];
        if (s < POS_MIN)
            return POS_MIN[POS_W-1:0];
        return s[POS_W-1:0];
    endfunction

    task automatic to_world(input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic [31:0] h, output longint ox, output longint oy);
        logic [31:0] zu;
        longint z, x, y, nx, dx, dy;
        zu = -h;
        z = longint'($signed(zu));
        x = longint'(ax) * 16384;
        y = longint'(ay) * 16384;
        if (z > 64'sh40000000 || z < -64'sh40000000)
        begin
            z = z > 0 ? z - 64'sh80000000 : z + 64'sh80000000;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                nx = x - dx;
                y = y + dy;
                z = z - longint'(arctan_tab[i]);
            end
            else
            begin
                nx = x + dx;
                y = y - dy;
                z = z + longint'(arctan_tab[i]);
            end
            x = nx;
        end
        ox = (x * 64'sd652032874 + (64'sd1 <<< 43)) >>> 44;
        oy = (y * 64'sd652032874 + (64'sd1 <<< 43)) >>> 44;
    endtask

    task automatic track_word(input item_kind_t kind, input logic [31:0] t,
                              input logic signed [15:0] rate,
                              input logic signed [15:0] ax, input logic signed [15:0] ay);
        fix_t f;
        logic [31:0] dt;
        if (kind == ITEM_GYRO)
        begin
            if (gyro_valid)
                yaw = yaw + {{16{last_rate[15]}}, last_rate} * (t - last_gyro_t);
            last_gyro_t = t;
            last_rate = rate;
            gyro_valid = 1'b1;
            return;
        end
        if (accel_seen >= 1)
        begin
            f.idx = accel_seen - 1;
            dt = t - last_accel_t;
            if (f.idx < {16'd0, skip_len})
            begin
                f.px = '0;
                f.py = '0;
            end
            else
            begin
                vx = add_sat(vx, scale_sat(world_ax[POS_W-1:0], dt));
                vy = add_sat(vy, scale_sat(world_ay[POS_W-1:0], dt));
                px = add_sat(px, scale_sat(vx, dt));
                py = add_sat(py, scale_sat(vy, dt));
                f.px = px;
                f.py = py;
            end
            fix_q.insert(fix_q.size(), f);
        end
        to_world(ax, ay, yaw, world_ax, world_ay);
        last_accel_t = t;
        if (accel_seen != 32'hFFFFFFFF)
            accel_seen = accel_seen + 1;
    endtask

    task automatic send_word(input item_kind_t kind, input logic [31:0] t,
                             input logic signed [15:0] rate,
                             input logic signed [15:0] ax, input logic signed [15:0] ay);
        if (!quiet && $urandom_range(99) < 8)
        begin
            sensor.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        sensor.valid <= 1'b1;
        sensor.op <= kind;
        sensor.sample_time <= t;
        sensor.gyro_rate <= rate;
        sensor.accel_x <= ax;
        sensor.accel_y <= ay;
        do
            @(posedge clk);
        while (!sensor.ready);
        track_word(kind, t, rate, ax, ay);
        words_sent++;
    endtask

    task automatic drain();
        sensor.valid <= 1'b0;
        @(posedge clk);
        while (fix_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_skip(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        skip_len = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] step_time();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            now_t = now_t + $urandom_range(200000);
        else if (r < 3)
            now_t = now_t - $urandom_range(50);
        else if (r < 10)
            now_t = now_t;
        else
            now_t = now_t + $urandom_range(1, 3000);
        return now_t;
    endfunction

    task automatic random_word(input int accel_pct);
        item_kind_t k;
        k = ($urandom_range(99) < accel_pct) ? ITEM_ACCEL : ITEM_GYRO;
        send_word(k, step_time(), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        set_skip(16'd2);
        now_t = 32'd1000;
        send_word(ITEM_ACCEL, now_t, 16'sd0, 16'sd1024, -16'sd1024);
        send_word(ITEM_GYRO, now_t, 16'sd32767, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t + 10, 16'sd0, 16'sd32767, 16'sd32767);
        send_word(ITEM_GYRO, now_t + 20, -16'sd32768, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t + 20, 16'sd0, -16'sd32768, -16'sd32768);
        send_word(ITEM_ACCEL, now_t + 20, 16'sd0, 16'sd32767, -16'sd32768);
        send_word(ITEM_ACCEL, now_t + 500, 16'sd0, -16'sd32768, 16'sd32767);
        send_word(ITEM_GYRO, now_t + 700, 16'sd5000, 16'sd0, 16'sd0);
        send_word(ITEM_GYRO, now_t + 800, -16'sd1, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t + 900, 16'sd0, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t + 950, 16'sd0, 16'sd1, -16'sd1);
        send_word(ITEM_GYRO, now_t + 940, 16'sd100, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t + 945, 16'sd0, 16'sd300, 16'sd700);
        now_t = now_t + 1000;
        drain();
    endtask

    task automatic test_random(input int n, input logic [15:0] skip);
        set_skip(skip);
        for (int i = 0; i < n; i++)
        begin
            quiet = (i >= n / 3 && i < n / 3 + QUIET_LEN);
            if (i == n / 2)
            begin
                drain();
            end
            random_word(50);
        end
        quiet = 0;
        drain();
    endtask

    task automatic test_time_extremes();
        set_skip(16'd0);
        now_t = 32'hFFFF_FF00;
        send_word(ITEM_GYRO, now_t, 16'sd7, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, now_t, 16'sd0, 16'sd32767, -16'sd32768);
        send_word(ITEM_ACCEL, 32'hFFFF_FFFF, 16'sd0, -16'sd32768, 16'sd32767);
        send_word(ITEM_GYRO, 32'h0000_0010, 16'sd1, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, 32'h0000_0020, 16'sd0, 16'sd32767, 16'sd32767);
        send_word(ITEM_ACCEL, 32'h8000_0000, 16'sd0, -16'sd32768, -16'sd32768);
        send_word(ITEM_ACCEL, 32'h7FFF_0000, 16'sd0, 16'sd32767, 16'sd0);
        send_word(ITEM_ACCEL, 32'hFFFF_0000, 16'sd0, 16'sd0, 16'sd0);
        send_word(ITEM_ACCEL, 32'hFFFF_0001, 16'sd0, 16'sd0, 16'sd0);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        fix_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (fix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: idx %0d pos %0d %0d",
                             result.sample_index, result.pos_x, result.pos_y);
            end
            else
            begin
                e = fix_q.pop_front();
                fixes_checked++;
                if (result.sample_index !== e.idx || result.pos_x !== e.px
                    || result.pos_y !== e.py)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected idx %0d pos %0d %0d, got %0d %0d %0d",
                                 e.idx, e.px, e.py, result.sample_index,
                                 result.pos_x, result.pos_y);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sensor.valid = 1'b0;
        sensor.op = ITEM_GYRO;
        sensor.sample_time = '0;
        sensor.gyro_rate = '0;
        sensor.accel_x = '0;
        sensor.accel_y = '0;
        result.ready = 1'b0;
        skip_len = '0;
        yaw = '0;
        last_gyro_t = '0;
        last_rate = '0;
        gyro_valid = 1'b0;
        last_accel_t = '0;
        world_ax = 0;
        world_ay = 0;
        vx = '0;
        vy = '0;
        px = '0;
        py = '0;
        accel_seen = '0;
        quiet = 0;
        mismatches = 0;
        fixes_checked = 0;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(900, 16'd0);
        test_random(150, 16'd65535);
        test_random(300, 16'd0);
        test_time_extremes();

        failed = (mismatches != 0) || (fix_q.size() != 0);
        $display("Sent %0d sensor words and checked %0d position words", words_sent,
                 fixes_checked);
        $display("with skip counts 0, 2 and 65535 and %0d mismatches.", mismatches);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
